// ===== src/bsc_pkg.sv =====
// Shared types, constants and helpers for the barometer compensation block.
package bsc_pkg;

  // Compensation constants.
  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] RAW_FULL    = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE = 64'd3125;
  localparam logic [31:0] TEMP_ROUND  = 32'd128;
  localparam int          ONE_SHIFT   = 47;
  localparam int          P1_SHIFT    = 33;
  localparam int          P4_SHIFT    = 35;

  // Configuration register indexes.
  localparam logic [1:0] REG_CAL_TEMP       = 2'd0;
  localparam logic [1:0] REG_CAL_PRESS_LOW  = 2'd1;
  localparam logic [1:0] REG_CAL_PRESS_HIGH = 2'd2;

  // Command codes.
  localparam logic CMD_TEMP  = 1'b0;
  localparam logic CMD_PRESS = 1'b1;

  typedef struct packed {
    logic        command;
    logic [19:0] raw_reading;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] temperature_centi;
    logic        [31:0] pressure_q24_8;
    logic               divide_fault;
  } out_item_t;

  // Steps of the compensation sequence; each one uses the multiplier or the divider.
  typedef enum logic [3:0] {
    ST_T0, ST_T1, ST_T2,
    ST_P0, ST_P1, ST_P2, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9, ST_P10, ST_P11
  } step_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic  load;
    logic  go;
    logic  publish;
    step_t step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic fault;
  } dp_status_t;

  // Sign extension helpers.
  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

// ===== src/bsc_mul.sv =====
// Multi-cycle 64 by 64 multiplier, low 64 bits, built from one 32 by 32 product a cycle.
module bsc_mul
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] op_a,
  input  logic [63:0] op_b,
  output logic        done,
  output logic [63:0] prod
);

  logic [63:0] a_q;
  logic [63:0] b_q;
  logic [63:0] acc;
  logic [1:0]  cnt;
  logic        busy;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] part;

  // Partial product selection: low by low, then the two cross terms.
  always_comb begin
    case (cnt)
      2'd0: begin
        mx = a_q[31:0];
        my = b_q[31:0];
      end
      2'd1: begin
        mx = a_q[63:32];
        my = b_q[31:0];
      end
      default: begin
        mx = a_q[31:0];
        my = b_q[63:32];
      end
    endcase
    part = {32'd0, mx} * {32'd0, my};
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 2'd0;
      end else if (busy) begin
        if (cnt == 2'd2) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 2'd1;
      end
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      a_q <= op_a;
      b_q <= op_b;
    end else if (busy) begin
      if (cnt == 2'd0) begin
        acc <= part;
      end else begin
        acc <= acc + {part[31:0], 32'd0};
      end
    end
  end

  assign prod = acc;

endmodule

// ===== src/bsc_div.sv =====
// Iterative signed 64-bit divider, truncating toward zero, one quotient bit a cycle.
module bsc_div
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot
);

  logic [64:0] rem;
  logic [63:0] qsh;
  logic [63:0] mag_d;
  logic        neg;
  logic [6:0]  cnt;
  logic        busy;
  logic [64:0] rem_sh;
  logic        fits;

  // One restoring step.
  always_comb begin
    rem_sh = {rem[63:0], qsh[63]};
    fits   = (rem_sh >= {1'b0, mag_d});
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 7'd1;
      end
    end
  end

  // Magnitudes, remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[63] ^ den[63];
      qsh   <= num[63] ? (64'd0 - num) : num;
      mag_d <= den[63] ? (64'd0 - den) : den;
      rem   <= 65'd0;
    end else if (busy) begin
      rem <= fits ? (rem_sh - {1'b0, mag_d}) : rem_sh;
      qsh <= {qsh[62:0], fits};
    end
  end

  assign quot = neg ? (64'd0 - qsh) : qsh;

endmodule

// ===== src/bsc_datapath.sv =====
// Datapath: calibration words, working registers, shared multiplier and divider.
module bsc_datapath
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  in_item_t    in_data,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  status,
  output out_item_t   out_data
);

  logic [63:0] cal_temp;
  logic [63:0] cal_low;
  logic [63:0] cal_high;
  logic [31:0] fine;

  logic        kind;
  logic [19:0] raw;
  logic [31:0] r_x;
  logic [31:0] r_y;
  logic [63:0] r_aa;
  logic [63:0] r_b;
  logic [63:0] r_c;
  logic [63:0] r_d;
  logic [63:0] r_n;
  logic [63:0] r_p;
  logic [63:0] r_s;
  logic [31:0] wk_temp;
  logic [31:0] wk_press;
  logic        wk_fault;

  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] prod;
  logic        mul_done;
  logic        mul_start;
  logic        div_start;
  logic        div_done;
  logic [63:0] quot;

  logic [31:0] t1;
  logic [31:0] x32;
  logic [31:0] d32;
  logic [63:0] av;
  logic [63:0] ps;
  logic [31:0] ft;
  logic [31:0] t5;
  logic [31:0] temp_c;
  logic [63:0] a_sh;
  logic [63:0] fin64;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_temp <= 64'd0;
      cal_low  <= 64'd0;
      cal_high <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_TEMP:       cal_temp <= cfg_data;
        REG_CAL_PRESS_LOW:  cal_low  <= cfg_data;
        REG_CAL_PRESS_HIGH: cal_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand forming for each step.
  always_comb begin
    t1  = {16'd0, cal_temp[15:0]};
    x32 = {15'd0, raw[19:3]} - {t1[30:0], 1'b0};
    d32 = {16'd0, raw[19:4]} - t1;
    av  = sx32(fine) - FINE_OFFSET;
    ps  = 64'($signed(r_p) >>> 13);
    case (cmd.step)
      ST_T0: begin
        mul_a = sx32(x32);
        mul_b = sx16(cal_temp[31:16]);
      end
      ST_T1: begin
        mul_a = sx32(d32);
        mul_b = sx32(d32);
      end
      ST_T2: begin
        mul_a = sx32(r_y);
        mul_b = sx16(cal_temp[47:32]);
      end
      ST_P0: begin
        mul_a = av;
        mul_b = av;
      end
      ST_P1: begin
        mul_a = r_aa;
        mul_b = sx16(cal_high[15:0]);
      end
      ST_P2: begin
        mul_a = av;
        mul_b = sx16(cal_low[63:48]);
      end
      ST_P4: begin
        mul_a = r_aa;
        mul_b = sx16(cal_low[31:16]);
      end
      ST_P5: begin
        mul_a = av;
        mul_b = sx16(cal_low[15:0]);
      end
      ST_P6: begin
        mul_a = (64'd1 << ONE_SHIFT) + r_c;
        mul_b = {48'd0, cal_temp[63:48]};
      end
      ST_P7: begin
        mul_a = ((RAW_FULL - {44'd0, raw}) << 31) - r_b;
        mul_b = PRESS_SCALE;
      end
      ST_P9: begin
        mul_a = ps;
        mul_b = ps;
      end
      ST_P10: begin
        mul_a = sx16(cal_high[63:48]);
        mul_b = r_s;
      end
      ST_P11: begin
        mul_a = sx16(cal_high[47:32]);
        mul_b = r_p;
      end
      default: begin
        mul_a = r_n;
        mul_b = r_d;
      end
    endcase
  end

  assign div_start = cmd.go && (cmd.step == ST_P8);
  assign mul_start = cmd.go && (cmd.step != ST_P8);

  bsc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  bsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (r_n),
    .den   (r_d),
    .done  (div_done),
    .quot  (quot)
  );

  // Post-processing of the finished product.
  always_comb begin
    ft     = r_x + 32'($signed(prod[31:0]) >>> 14);
    t5     = {ft[29:0], 2'b00} + ft + TEMP_ROUND;
    temp_c = 32'($signed(t5) >>> 8);
    a_sh   = 64'($signed(prod) >>> P1_SHIFT);
    fin64  = 64'($signed(r_p + r_c + 64'($signed(prod) >>> 19)) >>> 8)
           + (sx16(cal_high[31:16]) << 4);
  end

  // Fine temperature survives between items.
  always_ff @(posedge clk) begin
    if (rst) begin
      fine <= 32'd0;
    end else if (mul_done && (cmd.step == ST_T2)) begin
      fine <= ft;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind     <= in_data.command;
      raw      <= in_data.raw_reading;
      wk_fault <= 1'b0;
    end else if (div_done) begin
      r_p <= quot;
    end else if (mul_done) begin
      case (cmd.step)
        ST_T0:  r_x <= 32'($signed(prod[31:0]) >>> 11);
        ST_T1:  r_y <= 32'($signed(prod[31:0]) >>> 12);
        ST_T2:  wk_temp <= temp_c;
        ST_P0:  r_aa <= prod;
        ST_P1:  r_b <= prod;
        ST_P2:  r_b <= r_b + (prod << 17) + (sx16(cal_low[47:32]) << P4_SHIFT);
        ST_P4:  r_c <= 64'($signed(prod) >>> 8);
        ST_P5:  r_c <= r_c + (prod << 12);
        ST_P6: begin
          r_d      <= a_sh;
          wk_fault <= (a_sh == 64'd0);
        end
        ST_P7:  r_n <= prod;
        ST_P9:  r_s <= prod;
        ST_P10: r_c <= 64'($signed(prod) >>> 25);
        ST_P11: wk_press <= fin64[31:0];
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data.result_kind       <= kind;
      out_data.temperature_centi <= (kind == CMD_PRESS) ? 32'sd0 : $signed(wk_temp);
      out_data.pressure_q24_8    <= ((kind == CMD_PRESS) && !wk_fault) ? wk_press : 32'd0;
      out_data.divide_fault      <= (kind == CMD_PRESS) && wk_fault;
    end
  end

  assign status.done  = mul_done || div_done;
  assign status.fault = wk_fault;

endmodule

// ===== src/bsc_ctrl.sv =====
// Controller: sequences the compensation steps and the item handshakes.
module bsc_ctrl
  import bsc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  step_t  step;
  step_t  step_next;
  logic   publish;
  logic   last;

  assign in_ready = (state == S_IDLE);
  assign publish  = (state == S_FIN) && (!out_valid || out_ready);
  assign last     = (step == ST_T2) || (step == ST_P11);

  // Next state and step.
  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_ISSUE;
          step_next  = (in_command == CMD_PRESS) ? ST_P0 : ST_T0;
        end
      end
      S_ISSUE: begin
        // A zero divisor ends the pressure item early.
        if ((step == ST_P7) && status.fault) begin
          state_next = S_FIN;
        end else begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (status.done) begin
          if (last) begin
            state_next = S_FIN;
          end else begin
            state_next = S_ISSUE;
            step_next  = step_t'(step + 4'd1);
          end
        end
      end
      S_FIN: begin
        if (publish) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= ST_T0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd.load    = in_valid && in_ready;
    cmd.go      = (state == S_ISSUE) && !((step == ST_P7) && status.fault);
    cmd.publish = publish;
    cmd.step    = step;
  end

endmodule

// ===== src/baro_sensor_compensation.sv =====
// Top level of the barometer temperature and pressure compensation block.
// One item is in work at a time. Each step of the compensation passes through an issue
// state in the controller and then runs either on the divider or on a shared 64-bit
// multiplier that forms one 32 by 32 partial product a cycle. A temperature item runs
// three multiplies. A pressure item runs ten multiplies and one signed 64-bit division
// in a restoring divider that yields one quotient bit a cycle; a zero divisor ends it
// after the sixth multiply. The finished result sits in an output register, so the
// next item can be accepted in the cycle after a result is loaded there, while it
// waits to be taken; a result that finishes while the previous one still waits holds
// until that is taken.
module baro_sensor_compensation
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  bsc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_data.command),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .cmd        (cmd)
  );

  bsc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
